### sv/lse_pkg.sv
// Shared types, register codes and the per-channel filter function.
package lse_pkg;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    typedef struct packed {
        logic   frame_end;
        pixel_t pix;
    } result_t;

    localparam logic [1:0] REG_CENTER_WEIGHT = 2'd0;
    localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd1;
    localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd2;

    localparam logic [3:0]  CENTER_WEIGHT_RST = 4'd9;
    localparam logic [10:0] IMAGE_WIDTH_RST   = 11'd600;
    localparam logic [11:0] IMAGE_HEIGHT_RST  = 12'd475;

    localparam int FIFO_DEPTH = 4;

    // weight * center minus the eight neighbors, clamped to 0..255
    function automatic logic [7:0] lap_chan(input logic [3:0] wt, input logic [7:0] ctr,
                                            input logic [63:0] nbrs);
        logic [11:0]        prod;
        logic [10:0]        nsum;
        logic signed [13:0] acc;
        logic [7:0]         res;
        prod = 12'(wt) * 12'(ctr);
        nsum = '0;
        for (int k = 0; k < 8; k++)
        begin
            nsum = nsum + 11'(nbrs[k*8 +: 8]);
        end
        acc = $signed({2'b00, prod}) - $signed({3'b000, nsum});
        if (acc > 14'sd255)
            res = 8'hFF;
        else if (acc < 14'sd0)
            res = 8'h00;
        else
            res = acc[7:0];
        return res;
    endfunction

endpackage

### sv/lse_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lse_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/lse_out_fifo.sv
// Small result FIFO that decouples the filter pipeline from the output stream.
module lse_out_fifo
    import lse_pkg::*;
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    input  result_t                         wr_item,
    input  logic                            pop_ready,
    output logic                            out_valid,
    output result_t                         out_item,
    output logic [$clog2(FIFO_DEPTH+1)-1:0] level
);

    localparam int PW = $clog2(FIFO_DEPTH);
    localparam int LW = $clog2(FIFO_DEPTH+1);

    result_t       mem_reg [FIFO_DEPTH];
    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] tail_reg, tail_next;
    logic [LW-1:0] count_reg, count_next;
    logic          pop;

    assign out_valid = (count_reg != '0);
    assign out_item  = mem_reg[head_reg];
    assign level     = count_reg;
    assign pop       = out_valid && pop_ready;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push)
        begin
            tail_next = (tail_reg == PW'(FIFO_DEPTH-1)) ? '0 : tail_reg + PW'(1);
        end
        if (pop)
        begin
            head_next = (head_reg == PW'(FIFO_DEPTH-1)) ? '0 : head_reg + PW'(1);
        end
        if (push && !pop)
            count_next = count_reg + LW'(1);
        else if (pop && !push)
            count_next = count_reg - LW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[tail_reg] <= wr_item;
        end
    end

endmodule

### sv/laplacian_sharpen_edge_3x3.sv
// Streaming 3x3 Laplacian sharpen / edge filter over RGB pixels in raster order.
// Throughput: one item per cycle while s_tready is high; line buffers are dual-port RAMs read and
// written once per item. A pixel's result leaves after the item one line plus one pixel later is
// accepted, via the registered RAM read, the window registers and then the output FIFO.
// Reset clears counters, window and FIFO and loads weight 9, width 600, height 475;
// line buffer contents are left as they are.
module laplacian_sharpen_edge_3x3
    import lse_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4095
) (
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red_in, green_in, blue_in
    input  logic        s_tuser,   // action (1 = flush)
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // red_out, green_out, blue_out
    output logic        m_tlast    // frame_end
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 2);
    localparam int LW = $clog2(FIFO_DEPTH + 1);

    // configuration
    logic [3:0]  center_weight_reg;
    logic [10:0] image_width_reg;
    logic [11:0] image_height_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_weight_reg <= CENTER_WEIGHT_RST;
            image_width_reg   <= IMAGE_WIDTH_RST;
            image_height_reg  <= IMAGE_HEIGHT_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_CENTER_WEIGHT: center_weight_reg <= pwdata[3:0];
                REG_IMAGE_WIDTH:   image_width_reg   <= pwdata[10:0];
                REG_IMAGE_HEIGHT:  image_height_reg  <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_CENTER_WEIGHT: prdata = 32'(center_weight_reg);
            REG_IMAGE_WIDTH:   prdata = 32'(image_width_reg);
            REG_IMAGE_HEIGHT:  prdata = 32'(image_height_reg);
            default:           prdata = '0;
        endcase
    end

    // clamped frame size
    logic [31:0] w_raw, h_raw, w_clamp, h_clamp;
    logic [WW-1:0] eff_w, w_m1;
    logic [RW-1:0] eff_h, h_m1;

    always_comb
    begin
        w_raw = 32'(image_width_reg);
        h_raw = 32'(image_height_reg);
        if (w_raw < 32'd3)
            w_clamp = 32'd3;
        else if (w_raw > 32'(MAX_WIDTH))
            w_clamp = 32'(MAX_WIDTH);
        else
            w_clamp = w_raw;
        if (h_raw < 32'd3)
            h_clamp = 32'd3;
        else if (h_raw > 32'(MAX_HEIGHT))
            h_clamp = 32'(MAX_HEIGHT);
        else
            h_clamp = h_raw;
    end

    assign eff_w = w_clamp[WW-1:0];
    assign eff_h = h_clamp[RW-1:0];
    assign w_m1  = eff_w - WW'(1);
    assign h_m1  = eff_h - RW'(1);

    // position counters, all decided at acceptance
    logic [CW-1:0] in_column_reg, in_column_next;
    logic [RW-1:0] in_row_reg, in_row_next;
    logic [CW-1:0] out_column_reg, out_column_next;
    logic [RW-1:0] out_row_reg, out_row_next;

    logic          accept, active, draining, emit, border, last, col_wrap;
    logic [WW-1:0] in_col_inc;
    pixel_t        px;

    // pipeline stage 1: RAM data back, window shift
    logic          s1_valid_reg;
    logic          s1_emit_reg, s1_border_reg, s1_last_reg;
    logic [CW-1:0] s1_col_reg;
    pixel_t        s1_px_reg;

    // stage 2: result from the window
    logic          s2_valid_reg;
    logic          s2_border_reg, s2_last_reg;

    logic [LW-1:0] fifo_level;
    logic [LW-1:0] in_flight;

    assign in_flight = fifo_level + LW'(s1_valid_reg) + LW'(s2_valid_reg);
    assign s_tready  = (in_flight < LW'(FIFO_DEPTH));
    assign accept    = s_tvalid && s_tready;

    always_comb
    begin
        draining   = (in_row_reg >= eff_h);
        active     = accept && !(s_tuser && !draining);
        px         = draining ? pixel_t'('0) : pixel_t'(s_tdata);
        emit       = draining || (in_row_reg >= RW'(2))
                     || ((in_row_reg == RW'(1)) && (in_column_reg != '0));
        in_col_inc = WW'(in_column_reg) + WW'(1);
        col_wrap   = (in_col_inc >= eff_w);
        border     = (out_row_reg == '0) || (out_row_reg >= h_m1)
                     || (out_column_reg == '0) || (WW'(out_column_reg) >= w_m1);
        last       = (out_row_reg >= h_m1) && (WW'(out_column_reg) >= w_m1);

        in_column_next  = in_column_reg;
        in_row_next     = in_row_reg;
        out_column_next = out_column_reg;
        out_row_next    = out_row_reg;
        if (active)
        begin
            if (col_wrap)
            begin
                in_column_next = '0;
                if (in_row_reg <= eff_h)
                    in_row_next = in_row_reg + RW'(1);
            end
            else
            begin
                in_column_next = in_col_inc[CW-1:0];
            end
            if (emit)
            begin
                if (last)
                begin
                    in_column_next  = '0;
                    in_row_next     = '0;
                    out_column_next = '0;
                    out_row_next    = '0;
                end
                else if (WW'(out_column_reg) + WW'(1) >= eff_w)
                begin
                    out_column_next = '0;
                    out_row_next    = out_row_reg + RW'(1);
                end
                else
                begin
                    out_column_next = out_column_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_column_reg  <= '0;
            in_row_reg     <= '0;
            out_column_reg <= '0;
            out_row_reg    <= '0;
        end
        else
        begin
            in_column_reg  <= in_column_next;
            in_row_reg     <= in_row_next;
            out_column_reg <= out_column_next;
            out_row_reg    <= out_row_next;
        end
    end

    // line buffers: top holds two lines up, mid one line up
    pixel_t top_rd, mid_rd, top_eff, mid_eff;
    logic   byp_hit_reg;
    pixel_t byp_top_reg, byp_mid_reg;

    lse_ram #(
        .WIDTH ($bits(pixel_t)),
        .DEPTH (MAX_WIDTH)
    ) u_top_line (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata (mid_eff),
        .raddr (in_column_reg),
        .rdata (top_rd)
    );

    lse_ram #(
        .WIDTH ($bits(pixel_t)),
        .DEPTH (MAX_WIDTH)
    ) u_mid_line (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata (s1_px_reg),
        .raddr (in_column_reg),
        .rdata (mid_rd)
    );

    // a read that collides with the write of the item ahead gets the new data
    assign top_eff = byp_hit_reg ? byp_top_reg : top_rd;
    assign mid_eff = byp_hit_reg ? byp_mid_reg : mid_rd;

    always_ff @(posedge clk)
    begin
        byp_top_reg <= mid_eff;
        byp_mid_reg <= s1_px_reg;
        if (active)
        begin
            s1_px_reg     <= px;
            s1_col_reg    <= in_column_reg;
            s1_emit_reg   <= emit;
            s1_border_reg <= border;
            s1_last_reg   <= last;
        end
        if (s1_valid_reg)
        begin
            s2_border_reg <= s1_border_reg;
            s2_last_reg   <= s1_last_reg;
        end
    end

    pixel_t win_reg [9];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            byp_hit_reg  <= 1'b0;
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            s1_valid_reg <= active;
            s2_valid_reg <= s1_valid_reg && s1_emit_reg;
            byp_hit_reg  <= active && s1_valid_reg && (s1_col_reg == in_column_reg);
            if (s1_valid_reg)
            begin
                win_reg[0] <= win_reg[1];
                win_reg[1] <= win_reg[2];
                win_reg[2] <= top_eff;
                win_reg[3] <= win_reg[4];
                win_reg[4] <= win_reg[5];
                win_reg[5] <= mid_eff;
                win_reg[6] <= win_reg[7];
                win_reg[7] <= win_reg[8];
                win_reg[8] <= s1_px_reg;
            end
        end
    end

    // filter on the settled window
    logic [63:0] nb_r, nb_g, nb_b;
    result_t     res;

    always_comb
    begin
        nb_r = {win_reg[8].red,   win_reg[7].red,   win_reg[6].red,   win_reg[5].red,
                win_reg[3].red,   win_reg[2].red,   win_reg[1].red,   win_reg[0].red};
        nb_g = {win_reg[8].green, win_reg[7].green, win_reg[6].green, win_reg[5].green,
                win_reg[3].green, win_reg[2].green, win_reg[1].green, win_reg[0].green};
        nb_b = {win_reg[8].blue,  win_reg[7].blue,  win_reg[6].blue,  win_reg[5].blue,
                win_reg[3].blue,  win_reg[2].blue,  win_reg[1].blue,  win_reg[0].blue};
        res.frame_end = s2_last_reg;
        if (s2_border_reg)
        begin
            res.pix = win_reg[4];
        end
        else
        begin
            res.pix.red   = lap_chan(center_weight_reg, win_reg[4].red,   nb_r);
            res.pix.green = lap_chan(center_weight_reg, win_reg[4].green, nb_g);
            res.pix.blue  = lap_chan(center_weight_reg, win_reg[4].blue,  nb_b);
        end
    end

    result_t out_item;

    lse_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s2_valid_reg),
        .wr_item   (res),
        .pop_ready (m_tready),
        .out_valid (m_tvalid),
        .out_item  (out_item),
        .level     (fifo_level)
    );

    assign m_tdata = out_item.pix;
    assign m_tlast = out_item.frame_end;

endmodule
